/* src/polar_step_accumulator_macros.svh */
// ---------------------------------------------------------------------------
// polar step accumulator assertion macros
// shared assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef POLAR_STEP_ACCUMULATOR_MACROS_SVH
`define POLAR_STEP_ACCUMULATOR_MACROS_SVH

// checked only out of reset
`define PSA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define PSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/psa_pkg.sv */
// ---------------------------------------------------------------------------
// psa_pkg
// widths, cordic constants and codes for the polar step accumulator
// ---------------------------------------------------------------------------
package psa_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int LEN_W   = 16;
    localparam int DEG_W   = 9;
    localparam int POS_W   = 32;
    localparam int MAG_W   = 32;
    localparam int ANG_W   = 16;
    localparam int CNT_W   = 32;

    // rotation datapath
    localparam int XR_W      = 33;
    localparam int ZR_W      = 33;
    localparam int LEN_SHIFT = 14;
    localparam int DEG_FRAC  = 24;
    localparam int ROT_SHIFT = 38;
    localparam int DX_W      = 20;

    // vectoring datapath
    localparam int XV_W      = 38;
    localparam int ZV_W      = 34;
    localparam int POS_SCALE = 4;
    localparam int MAG_SHIFT = 28;
    localparam int ANG_SHIFT = 17;
    localparam int SPLIT     = 19;

    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    localparam int DEG_QUARTER = 90;
    localparam int DEG_3QUART  = 270;

    localparam logic [23:0] INV_GAIN = 24'd10188014;

    localparam logic signed [ZV_W-1:0] HALF_TURN_Z = 34'sd3019898880;

    localparam logic signed [ANG_W-1:0] HALF_TURN_OUT    = 16'sd23040;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN_OUT = 16'sd11520;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // atan(2^-i) in degrees, scaled by 2^24
    localparam logic [31:0] ATAN_DEG_TAB [32] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7,
        32'd4,         32'd2,         32'd1,         32'd0
    };

endpackage

/* src/polar_step_accumulator.sv */
// ---------------------------------------------------------------------------
// polar_step_accumulator
// running 2-d position from polar steps, with magnitude, angle and count
// ---------------------------------------------------------------------------
// s_ channel: one item per step; action add turns (step_length, direction_deg)
// into x and y parts by cordic rotation and adds them to the position, action
// clear zeroes the position and the step count.
// m_ channel: one item per input item, in order: position, magnitude, atan2
// angle in 1/128 degree, reached flag against target_distance, step count.
// cfg_wr_en / cfg_wr_data write target_distance; write only while idle.
// throughput: one item per cycle; the only feedback is the position add,
// which is a single stage between the rotation and vectoring cell rows.
// the whole pipeline advances together: while m_valid is high and m_ready
// low every stage holds and s_ready is low.
// reset clears position, count, target_distance and all valid flags.
// ---------------------------------------------------------------------------
module polar_step_accumulator #(
    parameter int CORDIC_STAGES = psa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [psa_pkg::MAG_W-1:0]            cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [psa_pkg::LEN_W-1:0]            s_step_length,
    input  logic [psa_pkg::DEG_W-1:0]            s_direction_deg,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [psa_pkg::POS_W-1:0]     m_pos_x,
    output logic signed [psa_pkg::POS_W-1:0]     m_pos_y,
    output logic [psa_pkg::MAG_W-1:0]            m_magnitude,
    output logic signed [psa_pkg::ANG_W-1:0]     m_angle,
    output logic                                 m_reached,
    output logic [psa_pkg::CNT_W-1:0]            m_step_total
);

    localparam int XR_W  = psa_pkg::XR_W;
    localparam int ZR_W  = psa_pkg::ZR_W;
    localparam int XV_W  = psa_pkg::XV_W;
    localparam int ZV_W  = psa_pkg::ZV_W;
    localparam int POS_W = psa_pkg::POS_W;
    localparam int CNT_W = psa_pkg::CNT_W;
    localparam int MAG_W = psa_pkg::MAG_W;
    localparam int ANG_W = psa_pkg::ANG_W;
    localparam int DX_W  = psa_pkg::DX_W;
    localparam int DEG_W = psa_pkg::DEG_W;
    localparam int PR_W  = XR_W + 25;
    localparam int HI_W  = XV_W - psa_pkg::SPLIT;
    localparam int PH_W  = HI_W + 25;
    localparam int PL_W  = psa_pkg::SPLIT + 26;
    localparam int MS_W  = 64;
    localparam int ZA_W  = ZV_W - psa_pkg::ANG_SHIFT;
    localparam int VSB_W = 2 * POS_W + CNT_W;

    localparam logic signed [24:0] INV_S = signed'({1'b0, psa_pkg::INV_GAIN});
    localparam logic signed [PR_W-1:0] ROT_HALF =
        PR_W'(64'd1 << (psa_pkg::ROT_SHIFT - 1));
    localparam logic signed [MS_W-1:0] MAG_HALF =
        MS_W'(64'd1 << (psa_pkg::MAG_SHIFT - 1));
    localparam logic signed [ZV_W-1:0] ANG_HALF =
        ZV_W'(64'd1 << (psa_pkg::ANG_SHIFT - 1));
    localparam logic signed [ZA_W-1:0] ANG_MAX = ZA_W'(psa_pkg::HALF_TURN_OUT);
    localparam logic signed [ZA_W-1:0] ANG_MIN = -ANG_MAX;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] a,
        input logic signed [DX_W-1:0]  d
    );
        logic signed [POS_W:0] sum;
        sum = (POS_W+1)'(a) + (POS_W+1)'(d);
        if (sum[POS_W] != sum[POS_W-1]) begin
            sat_add = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_add = sum[POS_W-1:0];
        end
    endfunction

    logic adv;
    logic [MAG_W-1:0] target_reg;

    // front stage
    logic [DEG_W-1:0]      deg_w;
    logic signed [9:0]     rot_wide;
    logic signed [7:0]     rot8;
    logic                  flip_w;
    logic                  a_valid_reg;
    logic signed [XR_W-1:0] a_x_reg;
    logic signed [ZR_W-1:0] a_z_reg;
    logic [1:0]            a_sb_reg;

    // rotation row
    logic                   rc_valid;
    logic signed [XR_W-1:0] rc_x, rc_y;
    logic signed [ZR_W-1:0] rc_z;
    logic [1:0]             rc_sb;

    // scale and round
    logic                   m1_valid_reg;
    logic signed [PR_W-1:0] m1_x_reg, m1_y_reg;
    logic [1:0]             m1_sb_reg;
    logic signed [PR_W-1:0] rx_sum, ry_sum, rx_sh, ry_sh;
    logic signed [DX_W-1:0] dx_w, dy_w;
    logic                   rd_valid_reg;
    logic signed [DX_W-1:0] rd_dx_reg, rd_dy_reg;
    logic                   rd_act_reg;

    // position state
    logic                    p_valid_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // vectoring front
    logic signed [XV_W-1:0] vx_w, vy_w;
    logic                   v0_valid_reg;
    logic signed [XV_W-1:0] v0_x_reg, v0_y_reg;
    logic signed [ZV_W-1:0] v0_z_reg;
    logic [VSB_W-1:0]       v0_sb_reg;

    // vectoring row
    logic                   vc_valid;
    logic signed [XV_W-1:0] vc_x, vc_y;
    logic signed [ZV_W-1:0] vc_z;
    logic [VSB_W-1:0]       vc_sb;
    logic signed [POS_W-1:0] vc_px, vc_py;

    // magnitude and angle
    logic signed [ZV_W-1:0] za_full;
    logic signed [ZA_W-1:0] za;
    logic signed [ANG_W-1:0] ang_w;
    logic                    ma_valid_reg;
    logic signed [PH_W-1:0]  ma_hi_reg;
    logic signed [PL_W-1:0]  ma_lo_reg;
    logic signed [ANG_W-1:0] ma_ang_reg;
    logic [VSB_W-1:0]        ma_sb_reg;
    logic                    mb_valid_reg;
    logic signed [MS_W-1:0]  mb_sum_reg;
    logic signed [ANG_W-1:0] mb_ang_reg;
    logic [VSB_W-1:0]        mb_sb_reg;
    logic signed [MS_W-1:0]  msh_w;
    logic [MAG_W-1:0]        mag_w;
    logic signed [POS_W-1:0] mb_px, mb_py;

    // output register
    logic                    m_valid_reg;
    logic signed [POS_W-1:0] m_pos_x_reg, m_pos_y_reg;
    logic [MAG_W-1:0]        m_mag_reg;
    logic signed [ANG_W-1:0] m_ang_reg;
    logic                    m_reached_reg;
    logic [CNT_W-1:0]        m_cnt_reg;

    assign adv     = ~m_valid_reg | m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    // direction fold into -90..90 with a flip of both parts
    always_comb begin
        deg_w = (s_direction_deg >= DEG_W'(psa_pkg::DEG_FULL))
              ? s_direction_deg - DEG_W'(psa_pkg::DEG_FULL) : s_direction_deg;
        flip_w = 1'b0;
        if (deg_w > DEG_W'(psa_pkg::DEG_QUARTER) && deg_w < DEG_W'(psa_pkg::DEG_3QUART)) begin
            rot_wide = signed'({1'b0, deg_w}) - 10'(psa_pkg::DEG_HALF);
            flip_w   = 1'b1;
        end else if (deg_w >= DEG_W'(psa_pkg::DEG_3QUART)) begin
            rot_wide = signed'({1'b0, deg_w}) - 10'(psa_pkg::DEG_FULL);
        end else begin
            rot_wide = signed'({1'b0, deg_w});
        end
        rot8 = rot_wide[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            v0_valid_reg <= 1'b0;
            ma_valid_reg <= 1'b0;
            mb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            a_valid_reg  <= s_valid;
            m1_valid_reg <= rc_valid;
            rd_valid_reg <= m1_valid_reg;
            p_valid_reg  <= rd_valid_reg;
            v0_valid_reg <= p_valid_reg;
            ma_valid_reg <= vc_valid;
            mb_valid_reg <= ma_valid_reg;
            m_valid_reg  <= mb_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_x_reg  <= XR_W'({s_step_length, {psa_pkg::LEN_SHIFT{1'b0}}});
            a_z_reg  <= {{(ZR_W-8-psa_pkg::DEG_FRAC){rot8[7]}}, rot8,
                         {psa_pkg::DEG_FRAC{1'b0}}};
            a_sb_reg <= {s_action, flip_w};
        end
    end

    psa_cordic_chain #(
        .STAGES (CORDIC_STAGES),
        .XW     (XR_W),
        .ZW     (ZR_W),
        .SBW    (2),
        .VECTOR (1'b0)
    ) u_rot_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_x      (a_x_reg),
        .in_y      ('0),
        .in_z      (a_z_reg),
        .in_sb     (a_sb_reg),
        .out_valid (rc_valid),
        .out_x     (rc_x),
        .out_y     (rc_y),
        .out_z     (rc_z),
        .out_sb    (rc_sb)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_x_reg  <= rc_x * INV_S;
            m1_y_reg  <= rc_y * INV_S;
            m1_sb_reg <= rc_sb;
        end
    end

    always_comb begin
        rx_sum = m1_x_reg + ROT_HALF;
        ry_sum = m1_y_reg + ROT_HALF;
        rx_sh  = rx_sum >>> psa_pkg::ROT_SHIFT;
        ry_sh  = ry_sum >>> psa_pkg::ROT_SHIFT;
        dx_w   = m1_sb_reg[0] ? -rx_sh[DX_W-1:0] : rx_sh[DX_W-1:0];
        dy_w   = m1_sb_reg[0] ? -ry_sh[DX_W-1:0] : ry_sh[DX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_dx_reg  <= dx_w;
            rd_dy_reg  <= dy_w;
            rd_act_reg <= m1_sb_reg[1];
        end
    end

    // position and count, the one feedback stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            cnt_reg   <= '0;
        end else if (adv && rd_valid_reg) begin
            if (rd_act_reg == psa_pkg::ACT_CLEAR) begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                cnt_reg   <= '0;
            end else begin
                pos_x_reg <= sat_add(pos_x_reg, rd_dx_reg);
                pos_y_reg <= sat_add(pos_y_reg, rd_dy_reg);
                if (cnt_reg != '1) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // into the right half plane before vectoring
    assign vx_w = {{(XV_W-POS_W-psa_pkg::POS_SCALE){pos_x_reg[POS_W-1]}}, pos_x_reg,
                   {psa_pkg::POS_SCALE{1'b0}}};
    assign vy_w = {{(XV_W-POS_W-psa_pkg::POS_SCALE){pos_y_reg[POS_W-1]}}, pos_y_reg,
                   {psa_pkg::POS_SCALE{1'b0}}};

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (pos_x_reg[POS_W-1]) begin
                v0_x_reg <= -vx_w;
                v0_y_reg <= -vy_w;
                v0_z_reg <= pos_y_reg[POS_W-1] ? -psa_pkg::HALF_TURN_Z : psa_pkg::HALF_TURN_Z;
            end else begin
                v0_x_reg <= vx_w;
                v0_y_reg <= vy_w;
                v0_z_reg <= '0;
            end
            v0_sb_reg <= {pos_x_reg, pos_y_reg, cnt_reg};
        end
    end

    psa_cordic_chain #(
        .STAGES (CORDIC_STAGES),
        .XW     (XV_W),
        .ZW     (ZV_W),
        .SBW    (VSB_W),
        .VECTOR (1'b1)
    ) u_vec_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v0_valid_reg),
        .in_x      (v0_x_reg),
        .in_y      (v0_y_reg),
        .in_z      (v0_z_reg),
        .in_sb     (v0_sb_reg),
        .out_valid (vc_valid),
        .out_x     (vc_x),
        .out_y     (vc_y),
        .out_z     (vc_z),
        .out_sb    (vc_sb)
    );

    assign vc_px = vc_sb[VSB_W-1 -: POS_W];
    assign vc_py = vc_sb[CNT_W +: POS_W];

    // angle rounding, clamp and axis cases
    always_comb begin
        za_full = (vc_z + ANG_HALF) >>> psa_pkg::ANG_SHIFT;
        za      = za_full[ZA_W-1:0];
        if (vc_px == '0 && vc_py == '0) begin
            ang_w = '0;
        end else if (vc_py == '0) begin
            ang_w = vc_px[POS_W-1] ? psa_pkg::HALF_TURN_OUT : '0;
        end else if (vc_px == '0) begin
            ang_w = vc_py[POS_W-1] ? -psa_pkg::QUARTER_TURN_OUT : psa_pkg::QUARTER_TURN_OUT;
        end else if (za > ANG_MAX) begin
            ang_w = psa_pkg::HALF_TURN_OUT;
        end else if (za < ANG_MIN) begin
            ang_w = -psa_pkg::HALF_TURN_OUT;
        end else begin
            ang_w = za[ANG_W-1:0];
        end
    end

    // magnitude gain product split in two partial products
    always_ff @(posedge aclk) begin
        if (adv) begin
            ma_hi_reg  <= signed'(vc_x[XV_W-1 -: HI_W]) * INV_S;
            ma_lo_reg  <= signed'({1'b0, vc_x[psa_pkg::SPLIT-1:0]}) * INV_S;
            ma_ang_reg <= ang_w;
            ma_sb_reg  <= vc_sb;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mb_sum_reg <= (MS_W'(ma_hi_reg) <<< psa_pkg::SPLIT) + MS_W'(ma_lo_reg) + MAG_HALF;
            mb_ang_reg <= ma_ang_reg;
            mb_sb_reg  <= ma_sb_reg;
        end
    end

    assign mb_px = mb_sb_reg[VSB_W-1 -: POS_W];
    assign mb_py = mb_sb_reg[CNT_W +: POS_W];

    always_comb begin
        msh_w = mb_sum_reg >>> psa_pkg::MAG_SHIFT;
        if ((mb_px == '0 && mb_py == '0) || msh_w[MS_W-1]) begin
            mag_w = '0;
        end else if (|msh_w[MS_W-2:MAG_W]) begin
            mag_w = '1;
        end else begin
            mag_w = msh_w[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pos_x_reg   <= mb_px;
            m_pos_y_reg   <= mb_py;
            m_mag_reg     <= mag_w;
            m_ang_reg     <= mb_ang_reg;
            m_reached_reg <= (mag_w >= target_reg);
            m_cnt_reg     <= mb_sb_reg[CNT_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pos_x      = m_pos_x_reg;
    assign m_pos_y      = m_pos_y_reg;
    assign m_magnitude  = m_mag_reg;
    assign m_angle      = m_ang_reg;
    assign m_reached    = m_reached_reg;
    assign m_step_total = m_cnt_reg;

endmodule

/* src/psa_cordic_cell.sv */
// ---------------------------------------------------------------------------
// psa_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ---------------------------------------------------------------------------
module psa_cordic_cell #(
    parameter int XW     = psa_pkg::XR_W,
    parameter int ZW     = psa_pkg::ZR_W,
    parameter int SBW    = 1,
    parameter int SHIFT  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic [SBW-1:0]       in_sb,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [ZW-1:0] out_z,
    output logic [SBW-1:0]       out_sb
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(psa_pkg::ATAN_DEG_TAB[SHIFT]);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SBW-1:0]       sb_reg;
    logic signed [XW-1:0] xs, ys;
    logic                 ccw;

    assign xs  = in_x >>> SHIFT;
    assign ys  = in_y >>> SHIFT;
    assign ccw = VECTOR ? in_y[XW-1] : ~in_z[ZW-1];

    always_comb begin
        if (ccw) begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end else begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            sb_reg <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_sb    = sb_reg;

endmodule

/* src/psa_cordic_chain.sv */
// ---------------------------------------------------------------------------
// psa_cordic_chain
// row of cordic cells, one micro-rotation per cell, all stalled together
// ---------------------------------------------------------------------------
module psa_cordic_chain #(
    parameter int STAGES = psa_pkg::CORDIC_STAGES_DEF,
    parameter int XW     = psa_pkg::XR_W,
    parameter int ZW     = psa_pkg::ZR_W,
    parameter int SBW    = 1,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic [SBW-1:0]       in_sb,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [ZW-1:0] out_z,
    output logic [SBW-1:0]       out_sb
);

    logic                 v_w  [STAGES+1];
    logic signed [XW-1:0] x_w  [STAGES+1];
    logic signed [XW-1:0] y_w  [STAGES+1];
    logic signed [ZW-1:0] z_w  [STAGES+1];
    logic [SBW-1:0]       sb_w [STAGES+1];

    assign v_w[0]  = in_valid;
    assign x_w[0]  = in_x;
    assign y_w[0]  = in_y;
    assign z_w[0]  = in_z;
    assign sb_w[0] = in_sb;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        psa_cordic_cell #(
            .XW     (XW),
            .ZW     (ZW),
            .SBW    (SBW),
            .SHIFT  (i),
            .VECTOR (VECTOR)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_w[i]),
            .in_x      (x_w[i]),
            .in_y      (y_w[i]),
            .in_z      (z_w[i]),
            .in_sb     (sb_w[i]),
            .out_valid (v_w[i+1]),
            .out_x     (x_w[i+1]),
            .out_y     (y_w[i+1]),
            .out_z     (z_w[i+1]),
            .out_sb    (sb_w[i+1])
        );
    end

    assign out_valid = v_w[STAGES];
    assign out_x     = x_w[STAGES];
    assign out_y     = y_w[STAGES];
    assign out_z     = z_w[STAGES];
    assign out_sb    = sb_w[STAGES];

endmodule

/* src/psa_checker.sv */
// ---------------------------------------------------------------------------
// psa_checker
// port-level checks on the polar step accumulator, bound to the top level
// ---------------------------------------------------------------------------
`include "polar_step_accumulator_macros.svh"

module psa_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [psa_pkg::POS_W-1:0]     m_pos_x,
    input logic signed [psa_pkg::POS_W-1:0]     m_pos_y,
    input logic [psa_pkg::MAG_W-1:0]            m_magnitude,
    input logic signed [psa_pkg::ANG_W-1:0]     m_angle,
    input logic [psa_pkg::CNT_W-1:0]            m_step_total
);

    // a stalled result item holds
    `PSA_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y)
            && $stable(m_step_total), "result item changed while stalled")

    // no result item straight out of reset
    `PSA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid,
        "result item valid after reset")

    // origin reports zero length and zero angle
    `PSA_ASSERT(a_origin, aclk, aresetn,
        m_valid && m_pos_x == 0 && m_pos_y == 0 |-> m_magnitude == 0 && m_angle == 0,
        "origin with nonzero magnitude or angle")

    // angle never beyond a half turn either way
    `PSA_ASSERT(a_angle_range, aclk, aresetn,
        m_valid |-> m_angle <= psa_pkg::HALF_TURN_OUT && m_angle >= -psa_pkg::HALF_TURN_OUT,
        "angle out of range")

endmodule

bind polar_step_accumulator psa_checker u_psa_checker (.*);
